### rtl/core/hcsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hermite curve segment generator package
// Widths, constants, sequencer states and control structs for the
// Hermite curve segment generator.
// ----------------------------------------------------------------------------
package hcsg_pkg;

    localparam int COORD_W   = 16;
    localparam int STEP_W    = 6;
    localparam int REM_W     = STEP_W + 1;
    localparam int T_W       = 17;
    localparam int FRAC_W    = 32;
    localparam int OPA_W     = 34;
    localparam int OPB_W     = 21;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int ACC_W     = 56;
    localparam int SAT_W     = ACC_W - FRAC_W;
    localparam int DIV_STEPS = T_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(63);
    localparam logic [STEP_W-1:0] MIN_STEPS = STEP_W'(1);
    localparam logic [T_W-1:0]    DIVIDEND  = {1'b1, {(T_W-1){1'b0}}};

    localparam logic [PROD_W-1:0] T3_HALF = PROD_W'(1) << 15;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2**(COORD_W-1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(2**(COORD_W-1)));

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SQ,
        S_CUBE,
        S_T3,
        S_TERM,
        S_DRAIN,
        S_ROUND,
        S_CLOSE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic to_y;
    } t_mac_ctl;

endpackage

### rtl/core/hcsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hermite step divider
// Restoring divider, one quotient bit per cycle: 2^16 divided by the step
// count, giving the per-step parameter increment and its remainder.
// ----------------------------------------------------------------------------
module hcsg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hcsg_pkg::STEP_W-1:0]   i_den,
    output logic                          o_done,
    output logic [hcsg_pkg::T_W-1:0]      o_quot,
    output logic [hcsg_pkg::STEP_W-1:0]   o_rem
);
    import hcsg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [T_W-1:0]       r_dvd;
    logic [T_W-1:0]       r_quot;
    logic [STEP_W-1:0]    r_rem;

    logic [REM_W-1:0]     w_trial;
    logic [REM_W-1:0]     w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_dvd[T_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= DIVIDEND;
            r_quot <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[T_W-2:0], 1'b0};
            r_quot <= {r_quot[T_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[STEP_W-1:0] : w_trial[STEP_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < i_den))
        else $error("divider remainder not below divisor");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with empty count");

endmodule

### rtl/core/hcsg_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hermite multiply-accumulate unit
// Shared signed multiplier with registered product, feeding the x and y
// coordinate accumulators in the cycle after.
// ----------------------------------------------------------------------------
module hcsg_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hcsg_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [hcsg_pkg::OPA_W-1:0]   i_a,
    input  logic signed [hcsg_pkg::OPB_W-1:0]   i_b,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_base_x,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_base_y,
    output logic signed [hcsg_pkg::PROD_W-1:0]  o_prod,
    output logic signed [hcsg_pkg::ACC_W-1:0]   o_acc_x,
    output logic signed [hcsg_pkg::ACC_W-1:0]   o_acc_y
);
    import hcsg_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pend;
    logic                     r_pend_y;
    logic signed [ACC_W-1:0]  r_acc_x;
    logic signed [ACC_W-1:0]  r_acc_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_pend_y <= 1'b0;
        end else begin
            r_pend   <= i_ctl.mul & i_ctl.acc;
            r_pend_y <= i_ctl.to_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc_x <= {{(ACC_W-COORD_W-FRAC_W){i_base_x[COORD_W-1]}}, i_base_x,
                        {FRAC_W{1'b0}}};
            r_acc_y <= {{(ACC_W-COORD_W-FRAC_W){i_base_y[COORD_W-1]}}, i_base_y,
                        {FRAC_W{1'b0}}};
        end else if (r_pend) begin
            if (r_pend_y) begin
                r_acc_y <= r_acc_y + ACC_W'(r_prod);
            end else begin
                r_acc_x <= r_acc_x + ACC_W'(r_prod);
            end
        end
    end

    assign o_prod  = r_prod;
    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;

    a_load_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> !r_pend)
        else $error("accumulator load collides with pending product");

endmodule

### rtl/core/hermite_curve_segment_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hermite curve segment generator
// Samples a cubic Hermite curve at t = k/N, k = 0..N, and emits the N
// segments between neighboring samples plus a closing segment to the end.
// Each sample is built by passes through the one shared multiplier, and the
// divider runs once per word before the first sample. A new word is taken
// only while busy is low. Results cannot be stalled.
// Reset (synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
module hermite_curve_segment_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_end_y,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_tangent_start_x,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_tangent_start_y,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_tangent_end_x,
    input  logic signed [hcsg_pkg::COORD_W-1:0] i_tangent_end_y,
    input  logic [hcsg_pkg::STEP_W-1:0]         i_step_count,
    output logic                                o_seg_valid,
    output logic signed [hcsg_pkg::COORD_W-1:0] o_seg_from_x,
    output logic signed [hcsg_pkg::COORD_W-1:0] o_seg_from_y,
    output logic signed [hcsg_pkg::COORD_W-1:0] o_seg_to_x,
    output logic signed [hcsg_pkg::COORD_W-1:0] o_seg_to_y,
    output logic                                o_last_segment
);
    import hcsg_pkg::*;

    localparam logic [2:0] TERM_BY   = 3'd0;
    localparam logic [2:0] TERM_AX   = 3'd1;
    localparam logic [2:0] TERM_AY   = 3'd2;
    localparam logic [2:0] TERM_CX   = 3'd3;
    localparam logic [2:0] TERM_CY   = 3'd4;

    function automatic logic signed [OPB_W-1:0] coef_a(
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] r0,
        input logic signed [COORD_W-1:0] r1
    );
        logic signed [OPB_W-1:0] d;
        d = OPB_W'(p0) - OPB_W'(p1);
        return (d <<< 1) + OPB_W'(r0) + OPB_W'(r1);
    endfunction

    function automatic logic signed [OPB_W-1:0] coef_b(
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] r0,
        input logic signed [COORD_W-1:0] r1
    );
        logic signed [OPB_W-1:0] d;
        d = OPB_W'(p1) - OPB_W'(p0);
        return (d <<< 1) + d - (OPB_W'(r0) <<< 1) - OPB_W'(r1);
    endfunction

    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] s;
        logic signed [SAT_W-1:0] r;
        s = acc + ROUND_HALF;
        r = s[ACC_W-1:FRAC_W];
        if (r > SAT_HI) begin
            return SAT_HI[COORD_W-1:0];
        end else if (r < SAT_LO) begin
            return SAT_LO[COORD_W-1:0];
        end
        return r[COORD_W-1:0];
    endfunction

    t_state                    r_state;
    t_state                    n_state;

    logic signed [COORD_W-1:0] r_p0x, r_p0y, r_p1x, r_p1y;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic signed [OPB_W-1:0]   r_ax, r_ay, r_bx, r_by;
    logic [STEP_W-1:0]         r_steps;
    logic [STEP_W-1:0]         r_k;
    logic [2:0]                r_cnt;
    logic [T_W-1:0]            r_q;
    logic [REM_W-1:0]          r_r;
    logic [T_W-1:0]            r_qinc;
    logic [REM_W-1:0]          r_rinc;
    logic [OPA_W-1:0]          r_t2;
    logic [OPA_W-1:0]          r_t3;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;

    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_from_x, r_from_y, r_to_x, r_to_y;
    logic                      r_last;

    logic                      w_accept;
    logic [STEP_W-1:0]         w_steps;
    t_mac_ctl                  w_ctl;
    logic signed [OPA_W-1:0]   w_op_a;
    logic signed [OPB_W-1:0]   w_op_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_acc_x, w_acc_y;
    logic [PROD_W-1:0]         w_t3_sum;
    logic signed [COORD_W-1:0] w_cur_x, w_cur_y;
    logic [REM_W:0]            w_rnext;
    logic [REM_W:0]            w_two_n;
    logic                      w_wrap;
    logic                      w_div_done;
    logic [T_W-1:0]            w_quot;
    logic [STEP_W-1:0]         w_rem;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    always_comb begin
        if (i_step_count == '0) begin
            w_steps = MIN_STEPS;
        end else if (i_step_count > MAX_STEPS) begin
            w_steps = MAX_STEPS;
        end else begin
            w_steps = i_step_count;
        end
    end

    assign w_t3_sum = w_prod + T3_HALF;
    assign w_cur_x  = round_sat(w_acc_x);
    assign w_cur_y  = round_sat(w_acc_y);
    assign w_rnext  = {1'b0, r_r} + {1'b0, r_rinc};
    assign w_two_n  = {1'b0, r_steps, 1'b0};
    assign w_wrap   = (w_rnext >= w_two_n);

    hcsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_den   (r_steps),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    hcsg_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_a      (w_op_a),
        .i_b      (w_op_b),
        .i_base_x (r_p0x),
        .i_base_y (r_p0y),
        .o_prod   (w_prod),
        .o_acc_x  (w_acc_x),
        .o_acc_y  (w_acc_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        w_op_a  = OPA_W'(r_q);
        w_op_b  = OPB_W'(r_q);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                w_ctl.load = 1'b1;
                w_ctl.mul  = 1'b1;
                n_state    = S_CUBE;
            end
            S_CUBE: begin
                w_ctl.mul = 1'b1;
                w_op_a    = w_prod[OPA_W-1:0];
                n_state   = S_T3;
            end
            S_T3: begin
                w_ctl.mul = 1'b1;
                w_ctl.acc = 1'b1;
                w_op_a    = r_t2;
                w_op_b    = r_bx;
                n_state   = S_TERM;
            end
            S_TERM: begin
                w_ctl.mul = 1'b1;
                w_ctl.acc = 1'b1;
                case (r_cnt)
                    TERM_BY: begin
                        w_ctl.to_y = 1'b1;
                        w_op_a     = r_t2;
                        w_op_b     = r_by;
                    end
                    TERM_AX: begin
                        w_op_a = r_t3;
                        w_op_b = r_ax;
                    end
                    TERM_AY: begin
                        w_ctl.to_y = 1'b1;
                        w_op_a     = r_t3;
                        w_op_b     = r_ay;
                    end
                    TERM_CX: begin
                        w_op_a = OPA_W'({r_q, 16'b0});
                        w_op_b = OPB_W'(r_cx);
                    end
                    TERM_CY: begin
                        w_ctl.to_y = 1'b1;
                        w_op_a     = OPA_W'({r_q, 16'b0});
                        w_op_b     = OPB_W'(r_cy);
                    end
                    default: begin
                        w_ctl = '0;
                    end
                endcase
                if (r_cnt == TERM_CY) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_k != '0 && r_k == r_steps) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_CLOSE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= '0;
            r_cnt <= '0;
        end else begin
            if (w_accept) begin
                r_k <= '0;
            end else if (r_state == S_ROUND && !(r_k != '0 && r_k == r_steps)) begin
                r_k <= r_k + STEP_W'(1);
            end
            if (r_state == S_T3) begin
                r_cnt <= TERM_BY;
            end else if (r_state == S_TERM) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p0x   <= i_start_x;
            r_p0y   <= i_start_y;
            r_p1x   <= i_end_x;
            r_p1y   <= i_end_y;
            r_cx    <= i_tangent_start_x;
            r_cy    <= i_tangent_start_y;
            r_ax    <= coef_a(i_start_x, i_end_x, i_tangent_start_x, i_tangent_end_x);
            r_ay    <= coef_a(i_start_y, i_end_y, i_tangent_start_y, i_tangent_end_y);
            r_bx    <= coef_b(i_start_x, i_end_x, i_tangent_start_x, i_tangent_end_x);
            r_by    <= coef_b(i_start_y, i_end_y, i_tangent_start_y, i_tangent_end_y);
            r_steps <= w_steps;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_qinc <= w_quot;
            r_rinc <= {w_rem, 1'b0};
            r_q    <= '0;
            r_r    <= {1'b0, r_steps};
        end else if (r_state == S_ROUND && !(r_k != '0 && r_k == r_steps)) begin
            if (w_wrap) begin
                r_r <= REM_W'(w_rnext - w_two_n);
                r_q <= r_q + r_qinc + T_W'(1);
            end else begin
                r_r <= w_rnext[REM_W-1:0];
                r_q <= r_q + r_qinc;
            end
        end
        if (r_state == S_CUBE) begin
            r_t2 <= w_prod[OPA_W-1:0];
        end
        if (r_state == S_T3) begin
            r_t3 <= w_t3_sum[OPA_W+15:16];
        end
        if (r_state == S_ROUND) begin
            r_prev_x <= w_cur_x;
            r_prev_y <= w_cur_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_out_valid <= (r_state == S_ROUND && r_k != '0) || (r_state == S_CLOSE);
            r_last      <= (r_state == S_CLOSE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND) begin
            r_from_x <= r_prev_x;
            r_from_y <= r_prev_y;
            r_to_x   <= w_cur_x;
            r_to_y   <= w_cur_y;
        end else if (r_state == S_CLOSE) begin
            r_from_x <= r_prev_x;
            r_from_y <= r_prev_y;
            r_to_x   <= r_p1x;
            r_to_y   <= r_p1y;
        end
    end

    assign o_seg_valid    = r_out_valid;
    assign o_seg_from_x   = r_from_x;
    assign o_seg_from_y   = r_from_y;
    assign o_seg_to_x     = r_to_x;
    assign o_seg_to_y     = r_to_y;
    assign o_last_segment = r_last;

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg_valid |-> ($past(r_state) == S_ROUND || $past(r_state) == S_CLOSE))
        else $error("segment strobe outside emit states");

    a_last_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg_valid && o_last_segment) |-> (o_seg_to_x == r_p1x && o_seg_to_y == r_p1y))
        else $error("closing segment does not end at end point");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_k <= r_steps))
        else $error("sample index beyond step count");

endmodule
